FILE: hdl/flss_pkg.sv
// Shared types and codes for the flow lease state store.
// No dependencies; imported by flss_table, flow_lease_state_store_core and the bench.
package flss_pkg;

  localparam int TableEntriesDef = 1024;
  localparam int KeyBitsDef      = 32;
  localparam int ValueBitsDef    = 32;
  localparam int SeqW            = 16;
  localparam int FieldKeyW       = 32;
  localparam int FieldValW       = 32;

  localparam logic [1:0] ACK_NEW     = 2'd0;
  localparam logic [1:0] ACK_MIGRATE = 2'd1;
  localparam logic [1:0] ACK_RENEW   = 2'd2;
  localparam logic [1:0] ACK_FULL    = 2'd3;

  localparam logic OP_NEW   = 1'b0;
  localparam logic OP_RENEW = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [FieldKeyW-1:0] flow_id;
    logic [SeqW-1:0]      seq_number;
    logic [FieldValW-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [1:0]           ack_kind;
    logic [SeqW-1:0]      ack_seq;
    logic [FieldValW-1:0] state_value;
    logic                 committed;
    logic                 replicate;
  } rsp_t;

  // write enables from the sequencer to the table
  typedef struct packed {
    logic key_we;
    logic data_we;
  } tbl_we_t;

endpackage

FILE: hdl/flss_table.sv
// Entry storage: key, value and last sequence memories, one shared address port pair.
// Depends on flss_pkg.
module flss_table
  import flss_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int KEY_BITS      = KeyBitsDef,
  parameter int VALUE_BITS    = ValueBitsDef
) (
  input  logic                             clk,
  input  tbl_we_t                          we,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
  input  logic [KEY_BITS-1:0]              wkey,
  input  logic [VALUE_BITS-1:0]            wval,
  input  logic [SeqW-1:0]                  wseq,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
  output logic [KEY_BITS-1:0]              rkey,
  output logic [VALUE_BITS-1:0]            rval,
  output logic [SeqW-1:0]                  rseq
);

  logic [KEY_BITS-1:0]   key_mem [TABLE_ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [TABLE_ENTRIES];
  logic [SeqW-1:0]       seq_mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we.key_we) begin
      key_mem[waddr] <= wkey;
    end
    if (we.data_we) begin
      val_mem[waddr] <= wval;
      seq_mem[waddr] <= wseq;
    end
  end

  always_ff @(posedge clk) begin
    rkey <= key_mem[raddr];
    rval <= val_mem[raddr];
    rseq <= seq_mem[raddr];
  end

endmodule

FILE: hdl/flow_lease_state_store_core.sv
// Top level of the flow lease state store: sequencer, key compare, result register.
// Depends on flss_pkg and flss_table.
//
// A request is taken when start is high and busy is low. Busy then stays high while the
// sequencer walks the occupied slots one at a time through the single table read port and
// the one key comparator: each slot visited is read and then compared, and a resolve step
// then decides the response and writes back. The walk stops at a matching key or at the
// last occupied slot; fill, the number of occupied slots, is at least one and at most
// TABLE_ENTRIES. Slots are never freed, so occupancy is always the low slots and a fill
// count replaces per-entry valid bits. The response sits on rsp for exactly one cycle with
// done high; the receiver cannot stall it, so capture it then. After reset the block writes
// slot 0 (key, value and sequence zero) in its init state before it takes a request.
// Configuration writes take effect at once and chain_enable is sampled at the resolve step,
// so write it only while the block is idle.
module flow_lease_state_store_core
  import flss_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int KEY_BITS      = KeyBitsDef,
  parameter int VALUE_BITS    = ValueBitsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  typedef enum logic [4:0] {
    ST_INIT    = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_READ    = 5'b00100,
    ST_CMP     = 5'b01000,
    ST_RESOLVE = 5'b10000
  } state_t;

  state_t state;
  logic   chain_enable;

  // latched request, key and value cut to storage width
  logic                  op;
  logic [KEY_BITS-1:0]   key;
  logic [SeqW-1:0]       seq;
  logic [VALUE_BITS-1:0] wval;

  logic [AW-1:0] idx;
  logic [CW-1:0] count;
  logic          hit;

  tbl_we_t               we;
  logic [AW-1:0]         waddr;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wdata;
  logic [SeqW-1:0]       wseq;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic [SeqW-1:0]       rseq;

  logic key_eq, last_slot, full, newer;
  rsp_t rsp_next;

  flss_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_BITS     (KEY_BITS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wkey (wkey),
    .wval (wdata),
    .wseq (wseq),
    .raddr(idx),
    .rkey (rkey),
    .rval (rval),
    .rseq (rseq)
  );

  assign busy      = (state != ST_IDLE);
  assign key_eq    = (rkey == key);
  assign last_slot = (CW'(idx) + CW'(1)) == count;
  assign full      = (count == FULL_COUNT);
  // on a fresh slot the stored sequence is zero
  assign newer     = (seq != '0) && ((hit ? rseq : '0) < seq);

  // resolve step: decide the response and the write-back; the init state writes slot 0
  always_comb begin
    rsp_next = '0;
    we       = '0;
    waddr    = hit ? idx : count[AW-1:0];
    wkey     = key;
    wdata    = '0;
    wseq     = '0;
    unique case (state)
      ST_INIT: begin
        we    = '{key_we: 1'b1, data_we: 1'b1};
        waddr = '0;
        wkey  = '0;
      end
      ST_RESOLVE: begin
        if (!hit && full) begin
          rsp_next.ack_kind = ACK_FULL;
        end else if (op == OP_NEW) begin
          if (hit) begin
            rsp_next.ack_kind    = ACK_MIGRATE;
            rsp_next.state_value = FieldValW'(rval);
          end else begin
            rsp_next.ack_kind = ACK_NEW;
            we = '{key_we: 1'b1, data_we: 1'b1};
          end
        end else begin
          rsp_next.ack_kind = ACK_RENEW;
          rsp_next.ack_seq  = seq;
          we.key_we         = !hit;
          we.data_we        = !hit || newer;
          if (newer) begin
            wdata              = wval;
            wseq               = seq;
            rsp_next.committed = 1'b1;
            rsp_next.replicate = chain_enable;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      chain_enable <= 1'b0;
      count        <= '0;
      done         <= 1'b0;
      idx          <= '0;
      hit          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        chain_enable <= cfg_wr_data;
      end
      unique case (state)
        ST_INIT: begin
          count <= CW'(1);
          state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            idx   <= '0;
            hit   <= 1'b0;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_CMP;
        ST_CMP: begin
          if (key_eq) begin
            hit   <= 1'b1;
            state <= ST_RESOLVE;
          end else if (last_slot) begin
            state <= ST_RESOLVE;
          end else begin
            idx   <= idx + AW'(1);
            state <= ST_READ;
          end
        end
        ST_RESOLVE: begin
          if (!hit && !full) begin
            count <= count + CW'(1);
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op   <= req.operation;
      key  <= KEY_BITS'(req.flow_id);
      seq  <= req.seq_number;
      wval <= VALUE_BITS'(req.write_value);
    end
    if (state == ST_RESOLVE) begin
      rsp <= rsp_next;
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("response while busy");
  a_repl_commit: assert property (@(posedge clk) disable iff (rst)
    done && rsp.replicate |-> rsp.committed)
    else $error("replicate without commit");
  a_commit_renew: assert property (@(posedge clk) disable iff (rst)
    done && rsp.committed |-> rsp.ack_kind == ACK_RENEW)
    else $error("commit on non-renew response");
  a_fill: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("fill count overrun");

endmodule

FILE: bench/tb.sv
// Self-checking bench for flow_lease_state_store_core: directed, random and table-full tests.
// Predicts every acknowledgement from its own copy of the lease table.
// Depends on flss_pkg and the core RTL.
`timescale 1ns / 1ps

module tb
  import flss_pkg::*;
();

  localparam int Slots     = 1024;
  localparam int KeyPool   = 48;
  localparam int WdogLimit = 20000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;
  logic cfg_wr_en;
  logic cfg_wr_data;

  flow_lease_state_store_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Own copy of the table; slots fill from the bottom and are never freed,
  // so a fill count stands in for per-slot valid bits.
  logic [FieldKeyW-1:0] lease_key[Slots];
  logic [FieldValW-1:0] lease_val[Slots];
  logic [SeqW-1:0]      lease_seq[Slots];
  int                   lease_fill;
  logic                 chain_on;

  rsp_t                 ack_queue[$];
  logic [FieldKeyW-1:0] key_pool[KeyPool];
  int                   mismatches = 0;
  int                   idle_pct;
  int                   quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int find_lease(logic [FieldKeyW-1:0] k);
    for (int i = 0; i < lease_fill; i++) begin
      if (lease_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one request to the table copy and returns the acknowledgement it earns.
  function automatic rsp_t lease_ack(req_t r);
    rsp_t a;
    int   s;
    a = '0;
    a.ack_kind = ACK_FULL;
    s = find_lease(r.flow_id);
    if (s < 0 && lease_fill < Slots) begin
      // a new lease on an unknown key, or a renew that creates it
      lease_key[lease_fill] = r.flow_id;
      lease_val[lease_fill] = '0;
      lease_seq[lease_fill] = '0;
      lease_fill++;
      if (r.operation == OP_NEW) begin
        a.ack_kind = ACK_NEW;
        return a;
      end
      s = lease_fill - 1;
    end
    if (s < 0) return a;  // table full: nothing inserted
    if (r.operation == OP_NEW) begin
      a.ack_kind    = ACK_MIGRATE;
      a.state_value = lease_val[s];
    end else begin
      a.ack_kind = ACK_RENEW;
      a.ack_seq  = r.seq_number;
      // commit only a strictly newer, nonzero sequence
      if (r.seq_number != '0 && lease_seq[s] < r.seq_number) begin
        lease_val[s] = r.write_value;
        lease_seq[s] = r.seq_number;
        a.committed  = 1'b1;
        a.replicate  = chain_on;
      end
    end
    return a;
  endfunction

  // Result checker and watchdog
  always @(posedge clk) begin
    rsp_t want;
    if (rst || !(done || (start && !busy))) quiet_cycles <= quiet_cycles + 1;
    else quiet_cycles <= 0;
    if (quiet_cycles >= WdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (!rst && done) begin
      if (ack_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected ack %h", rsp);
      end else begin
        want = ack_queue.pop_front();
        if (rsp.ack_kind !== want.ack_kind || rsp.ack_seq !== want.ack_seq ||
            rsp.state_value !== want.state_value || rsp.committed !== want.committed ||
            rsp.replicate !== want.replicate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ack mismatch: kind %0d/%0d seq %h/%h val %h/%h comm %b/%b repl %b/%b",
                     want.ack_kind, rsp.ack_kind, want.ack_seq, rsp.ack_seq,
                     want.state_value, rsp.state_value, want.committed, rsp.committed,
                     want.replicate, rsp.replicate);
        end
      end
    end
  end

  // Sends one request; start stays high for back-to-back requests, bar a random idle gap.
  task automatic send_request(logic op, logic [FieldKeyW-1:0] k, logic [SeqW-1:0] sq,
                              logic [FieldValW-1:0] v);
    req_t r;
    r.operation   = op;
    r.flow_id     = k;
    r.seq_number  = sq;
    r.write_value = v;
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    ack_queue.insert(ack_queue.size(), lease_ack(r));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold off until every expected ack is in, then let the block settle.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (ack_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_chain(logic en);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chain_on = en;
    @(posedge clk);
  endtask

  task automatic test_directed;
    idle_pct = 0;
    set_chain(1'b1);
    send_request(OP_NEW,   32'h0, 16'h0, 32'h0);               // preloaded key 0: migrate
    send_request(OP_RENEW, 32'h0, 16'h0, 32'hDEADBEEF);        // read-only renew
    send_request(OP_RENEW, 32'h0, 16'h1, 32'hFFFFFFFF);        // commit
    send_request(OP_RENEW, 32'h0, 16'h1, 32'h12345678);        // equal sequence
    send_request(OP_RENEW, 32'h0, 16'hFFFF, 32'h00000001);     // top sequence
    send_request(OP_RENEW, 32'h0, 16'h5, 32'h55555555);        // stale
    send_request(OP_NEW,   32'h0, 16'hFFFF, 32'hFFFFFFFF);     // migrate returns value
    send_request(OP_NEW,   32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_request(OP_NEW,   32'hFFFFFFFF, 16'h0, 32'h0);
    set_chain(1'b0);
    send_request(OP_RENEW, 32'hFFFFFFFF, 16'hFFFF, 32'h0);
    send_request(OP_RENEW, 32'hFFFFFFFF, 16'hFFFF, 32'hAAAAAAAA);
    send_request(OP_NEW,   32'hFFFFFFFF, 16'h0, 32'h0);
    send_request(OP_RENEW, 32'h12345678, 16'h0, 32'h87654321); // renew inserts, no commit
    send_request(OP_RENEW, 32'h9ABCDEF0, 16'h3, 32'h0F0F0F0F); // renew inserts and commits
    send_request(OP_NEW,   32'h9ABCDEF0, 16'h0, 32'h0);
    send_request(OP_RENEW, 32'h80000001, 16'h8000, 32'h80000000);
  endtask

  task automatic test_random(int n, int pct);
    logic [FieldKeyW-1:0] k;
    logic [SeqW-1:0]      sq;
    int                   s;
    int                   pick;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      // mostly pooled flows; an occasional fresh key grows the table slowly
      k = ($urandom_range(99) < 3) ? $urandom() : key_pool[$urandom_range(KeyPool - 1)];
      s = find_lease(k);
      pick = $urandom_range(99);
      if (pick < 60 && s >= 0 && lease_seq[s] < 16'hFFF0)
        sq = SeqW'(lease_seq[s] + $urandom_range(1, 8));   // in-order sequence
      else if (pick < 75)
        sq = '0;
      else
        sq = SeqW'($urandom());
      send_request(1'($urandom_range(1)), k, sq, $urandom());
    end
  endtask

  task automatic test_table_full;
    logic [FieldKeyW-1:0] k;
    idle_pct = 0;
    set_chain(1'b1);
    while (lease_fill < Slots) begin
      k = $urandom();
      send_request(1'($urandom_range(1)), k, SeqW'($urandom_range(1)), $urandom());
    end
    send_request(OP_NEW,   32'h7E57F011, 16'h0, 32'h0);
    send_request(OP_RENEW, 32'h7E57F012, 16'hFFFF, 32'hFFFFFFFF);
    send_request(OP_NEW,   key_pool[1], 16'h0, 32'h0);
    send_request(OP_RENEW, key_pool[1], 16'hFFFF, 32'h13579BDF);
    send_request(OP_NEW,   key_pool[1], 16'h0, 32'h0);
    send_request(OP_RENEW, k, 16'hFFFF, 32'h2468ACE0);         // last slot filled
    send_request(OP_NEW,   k, 16'h0, 32'h0);
    send_request(OP_RENEW, 32'h7E57F013, 16'h0, 32'h0);
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    idle_pct     = 0;
    chain_on     = 1'b0;
    lease_fill   = 1;
    lease_key[0] = '0;
    lease_val[0] = '0;
    lease_seq[0] = '0;
    key_pool[0]  = '0;
    key_pool[1]  = '1;
    for (int i = 2; i < KeyPool; i++) key_pool[i] = $urandom();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(110, 0);
    set_chain(1'b1);
    test_random(110, 45);
    drain();                       // sender waits for every ack once
    test_random(110, 11);
    set_chain(1'b0);
    test_random(110, 0);
    test_table_full();

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && ack_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/flss_pkg.sv
hdl/flss_table.sv
hdl/flow_lease_state_store_core.sv
bench/tb.sv
